@@ rtl/fac_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the frustum box cull block
// no dependencies

package fac_pkg;

    localparam int MAX_PLANES_DEF = 6;
    localparam int PLANE_SLOTS    = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int COUNT_W        = 3;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PLANES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_0       = 3'd1;

    typedef logic signed [15:0] coord_t;
    typedef logic [14:0]        half_t;
    typedef logic [COUNT_W-1:0] count_t;

    // one plane as packed in its register: offset on top, normal x at the bottom
    typedef struct packed {
        logic signed [15:0] offset;
        logic signed [15:0] nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
    } plane_t;

    // load enables of the three datapath stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

@@ rtl/fac_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces: box input, result output, config write
// depends on fac_pkg

interface fac_box_if;
    import fac_pkg::*;
    logic   valid;
    logic   ready;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    half_t  half_x;
    half_t  half_y;
    half_t  half_z;

    modport source (output valid, center_x, center_y, center_z, half_x, half_y, half_z,
                    input ready);
    modport sink   (input valid, center_x, center_y, center_z, half_x, half_y, half_z,
                    output ready);
endinterface

interface fac_result_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink   (input valid, visible, output ready);
endinterface

interface fac_cfg_if;
    import fac_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/fac_plane.sv @@
`timescale 1ns / 1ps
// one clipping plane test, three register stages: products, sums, sign of d + r
// depends on fac_pkg

module fac_plane (
    input  logic               clk,
    input  fac_pkg::stage_en_t en,
    input  fac_pkg::plane_t    plane,
    input  fac_pkg::coord_t    center_x,
    input  fac_pkg::coord_t    center_y,
    input  fac_pkg::coord_t    center_z,
    input  fac_pkg::half_t     half_x,
    input  fac_pkg::half_t     half_y,
    input  fac_pkg::half_t     half_z,
    output logic               reject
);
    import fac_pkg::*;

    logic [15:0] mag_x, mag_y, mag_z;

    // stage 1: products
    logic [30:0]        rx_reg, ry_reg, rz_reg;
    logic signed [31:0] dx_reg, dy_reg, dz_reg;
    logic signed [15:0] off_reg;
    logic [30:0]        rx_next, ry_next, rz_next;
    logic signed [31:0] dx_next, dy_next, dz_next;

    // stage 2: radius and distance
    logic [32:0]        r_reg, r_next;
    logic signed [33:0] d_reg, d_next;

    // stage 3: box wholly on the negative side
    logic               reject_reg;
    logic signed [34:0] slack;

    // magnitude of a normal component, -2.0 maps to 0x8000
    assign mag_x = plane.nx[15] ? 16'(~plane.nx + 16'sd1) : 16'(plane.nx);
    assign mag_y = plane.ny[15] ? 16'(~plane.ny + 16'sd1) : 16'(plane.ny);
    assign mag_z = plane.nz[15] ? 16'(~plane.nz + 16'sd1) : 16'(plane.nz);

    always_comb
    begin
        rx_next = 31'(half_x) * 31'(mag_x);
        ry_next = 31'(half_y) * 31'(mag_y);
        rz_next = 31'(half_z) * 31'(mag_z);
        dx_next = 32'(center_x) * 32'(plane.nx);
        dy_next = 32'(center_y) * 32'(plane.ny);
        dz_next = 32'(center_z) * 32'(plane.nz);
    end

    always_comb
    begin
        r_next = 33'(rx_reg) + 33'(ry_reg) + 33'(rz_reg);
        // offset moves from Q8.8 to the product scale by 14 bits
        d_next = 34'(dx_reg) + 34'(dy_reg) + 34'(dz_reg)
               + 34'($signed({off_reg, 14'b0}));
    end

    assign slack = 35'(d_reg) + 35'($signed({2'b0, r_reg}));

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            rz_reg  <= rz_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dz_reg  <= dz_next;
            off_reg <= plane.offset;
        end
        if (en.s2)
        begin
            r_reg <= r_next;
            d_reg <= d_next;
        end
        if (en.s3)
        begin
            reject_reg <= slack[34];
        end
    end

    assign reject = reject_reg;

endmodule

@@ rtl/frustum_aabb_cull_test.sv @@
`timescale 1ns / 1ps
// Box-against-frustum cull test, top level.
// Depends on fac_pkg, the channel interfaces in fac_if and fac_plane.
//
// Channels: box (sink) carries a box center (signed Q8.8) and half-extents
// (Q7.8); result (source) carries one visible bit per box, in box order;
// cfg (sink) writes active_planes at index 0 and planes 0..5 at indexes 1..6,
// always ready, other indexes are dropped. Write cfg only while no box is
// in flight.
// Throughput: one box per cycle unless result stalls. Every plane has its own unit with six
// parallel multipliers (15x16 and signed 16x16), so nothing is shared between boxes.
// Pipeline: after the box transfer, the box passes the products, sums and per-plane
// sign registers, then the combining output register, before its result is valid.
// Stall: each stage holds while its successor is full and not moving; empty
// stages keep filling, so up to four boxes sit in the pipe under a stall,
// and box.ready drops only when all of them are occupied.
// Reset: all pipeline valid bits clear, active_planes and the planes go to
// zero, so with no configuration every box is visible.

module frustum_aabb_cull_test #(
    parameter int MAX_PLANES = fac_pkg::MAX_PLANES_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    fac_box_if.sink      box,
    fac_result_if.source result,
    fac_cfg_if.sink      cfg
);
    import fac_pkg::*;

    count_t    active_reg;
    plane_t    plane_reg [MAX_PLANES];
    count_t    count_sat;
    logic [MAX_PLANES-1:0] mask;
    logic [MAX_PLANES-1:0] reject;

    logic      v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic      visible_reg;
    logic      out_en;
    stage_en_t en;

    // pipeline flow: a stage loads when it is empty or its content moves on
    assign out_en = !out_valid_reg || result.ready;
    assign en.s3  = !v3_reg || out_en;
    assign en.s2  = !v2_reg || en.s3;
    assign en.s1  = !v1_reg || en.s2;

    assign box.ready = en.s1;
    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (cfg.valid && cfg.index == REG_ACTIVE_PLANES)
        begin
            active_reg <= cfg.data[COUNT_W-1:0];
        end
    end

    for (genvar p = 0; p < MAX_PLANES; p++)
    begin : g_plane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                plane_reg[p] <= '0;
            end
            else if (cfg.valid && cfg.index == REG_PLANE_0 + CFG_IDX_W'(p))
            begin
                plane_reg[p] <= cfg.data;
            end
        end

        fac_plane u_plane (
            .clk      (clk),
            .en       (en),
            .plane    (plane_reg[p]),
            .center_x (box.center_x),
            .center_y (box.center_y),
            .center_z (box.center_z),
            .half_x   (box.half_x),
            .half_y   (box.half_y),
            .half_z   (box.half_z),
            .reject   (reject[p])
        );

        assign mask[p] = COUNT_W'(p) < count_sat;
    end

    // counts past the number of plane units saturate
    assign count_sat = (active_reg > COUNT_W'(MAX_PLANES)) ? COUNT_W'(MAX_PLANES)
                                                           : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
                v1_reg <= box.valid;
            if (en.s2)
                v2_reg <= v1_reg;
            if (en.s3)
                v3_reg <= v2_reg;
            if (out_en)
                out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
            visible_reg <= !(|(reject & mask));
    end

    assign result.valid   = out_valid_reg;
    assign result.visible = visible_reg;

    // no active planes means the box is always visible
    a_zero_planes_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && out_en && active_reg == '0) |=> result.visible)
        else $error("box rejected with no active planes");

    // an empty output register never holds back the input
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> box.ready)
        else $error("input stalled while output register empty");

    // a box in the last stage is not dropped under a stall
    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !out_en) |=> v3_reg)
        else $error("stalled box lost from last stage");

    // every accepted box lands in the first stage
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (box.valid && box.ready) |=> v1_reg)
        else $error("accepted box missing from first stage");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the frustum box cull block: directed boxes, then
// random boxes over several plane setups with random sender idling and receiver stalls
// depends on fac_pkg, the channel interfaces in fac_if and frustum_aabb_cull_test

module testbench;
    import fac_pkg::*;

    typedef struct packed {
        coord_t center_x;
        coord_t center_y;
        coord_t center_z;
        half_t  half_x;
        half_t  half_y;
        half_t  half_z;
    } box_t;

    class cull_scoreboard;
        logic [COUNT_W-1:0] active_planes;
        plane_t             planes[PLANE_SLOTS];
        bit                 visible_q[$];
        int unsigned        box_seq_q[$];
        int unsigned        boxes_seen;
        int unsigned        results_seen;
        int unsigned        visible_seen;
        int unsigned        culled_seen;
        int unsigned        errors;

        function new();
            active_planes = '0;
            foreach (planes[i])
                planes[i] = '0;
            boxes_seen   = 0;
            results_seen = 0;
            visible_seen = 0;
            culled_seen  = 0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ACTIVE_PLANES)
                active_planes = data[COUNT_W-1:0];
            else if (idx >= REG_PLANE_0 && int'(idx) < int'(REG_PLANE_0) + PLANE_SLOTS)
                planes[idx - REG_PLANE_0] = data;
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // box is culled once some active plane has it wholly on the negative side
        function bit box_visible(box_t b);
            int     count;
            longint cx, cy, cz, hx, hy, hz;
            longint nx, ny, nz, off, reach, center_d;
            count = (active_planes > MAX_PLANES_DEF) ? MAX_PLANES_DEF : int'(active_planes);
            cx = longint'(b.center_x);
            cy = longint'(b.center_y);
            cz = longint'(b.center_z);
            hx = longint'(b.half_x);
            hy = longint'(b.half_y);
            hz = longint'(b.half_z);
            for (int i = 0; i < count; i++)
            begin
                nx  = longint'(planes[i].nx);
                ny  = longint'(planes[i].ny);
                nz  = longint'(planes[i].nz);
                off = longint'(planes[i].offset);
                reach    = magnitude(hx * nx) + magnitude(hy * ny) + magnitude(hz * nz);
                center_d = nx * cx + ny * cy + nz * cz + off * 16384;
                if (center_d < -reach)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_box(box_t b);
            visible_q.push_back(box_visible(b));
            box_seq_q.push_back(boxes_seen);
            boxes_seen++;
        endfunction

        function void check_result(logic visible);
            bit          want;
            int unsigned seq;
            results_seen++;
            if (visible === 1'b1)
                visible_seen++;
            else
                culled_seen++;
            if (visible_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: visible=%b with no box pending",
                             visible);
                return;
            end
            want = visible_q.pop_front();
            seq  = box_seq_q.pop_front();
            if (visible !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("box %0d: visible expected %b, got %b", seq, want, visible);
            end
        endfunction

        function int pending();
            return visible_q.size();
        endfunction
    endclass

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int PHASES      = 8;
    localparam int PHASE_BOXES = 175;
    localparam int DRAIN_WAIT  = 6;

    logic clk;
    logic rst_n;

    fac_box_if    box_ch();
    fac_result_if res_ch();
    fac_cfg_if    cfg_ch();

    frustum_aabb_cull_test dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .box    (box_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    cull_scoreboard sb = new();

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned reg_writes;

    int phase_planes[PHASES] = '{6, 1, 7, 3, 0, 6, 2, 5};
    int phase_idle[PHASES]   = '{0, 51, 0, 24, 0, 51, 0, 24};
    int phase_stall[PHASES]  = '{0, 0, 51, 24, 0, 0, 51, 24};

    always #5 clk = ~clk;

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= stall_pct);

    // watch all three channels on the same edge the block sees
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                sb.write_reg(cfg_ch.index, cfg_ch.data);
                reg_writes++;
            end
            if (box_ch.valid && box_ch.ready)
                sb.note_box({box_ch.center_x, box_ch.center_y, box_ch.center_z,
                             box_ch.half_x, box_ch.half_y, box_ch.half_z});
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.visible);
        end
    end

    // called at a clock edge; returns at the edge of the transfer with valid still high
    task automatic send_box(input box_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            box_ch.valid <= 1'b0;
            @(posedge clk);
        end
        box_ch.valid    <= 1'b1;
        box_ch.center_x <= b.center_x;
        box_ch.center_y <= b.center_y;
        box_ch.center_z <= b.center_z;
        box_ch.half_x   <= b.half_x;
        box_ch.half_y   <= b.half_y;
        box_ch.half_z   <= b.half_z;
        do
            @(posedge clk);
        while (!box_ch.ready);
    endtask

    // lowers box valid and waits out every pending result plus the pipe depth
    task automatic drain_results();
        box_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic box_t make_box(int cx, int cy, int cz, int hx, int hy, int hz);
        box_t b;
        b.center_x = 16'(cx);
        b.center_y = 16'(cy);
        b.center_z = 16'(cz);
        b.half_x   = 15'(hx);
        b.half_y   = 15'(hy);
        b.half_z   = 15'(hz);
        return b;
    endfunction

    function automatic logic [63:0] make_plane(int nx, int ny, int nz, int off);
        plane_t p;
        p.nx     = 16'(nx);
        p.ny     = 16'(ny);
        p.nz     = 16'(nz);
        p.offset = 16'(off);
        return p;
    endfunction

    function automatic logic [15:0] edge_value16();
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] edge_half();
        case ($urandom_range(3))
            0: return 15'h0000;
            1: return 15'h7fff;
            2: return 15'h0001;
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] random_plane();
        plane_t p;
        int     axis;
        case ($urandom_range(3))
            0: p = {$urandom, $urandom};
            1:
            begin
                // axis-aligned unit normal, random offset
                axis = $urandom_range(2);
                p = '0;
                p.offset = 16'($urandom);
                if (axis == 0)
                    p.nx = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                else if (axis == 1)
                    p.ny = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                else
                    p.nz = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            end
            2: p = {edge_value16(), edge_value16(), edge_value16(), edge_value16()};
            default:
            begin
                p.nx     = 16'($urandom_range(32768) - 16384);
                p.ny     = 16'($urandom_range(32768) - 16384);
                p.nz     = 16'($urandom_range(32768) - 16384);
                p.offset = 16'($urandom_range(8192) - 4096);
            end
        endcase
        return p;
    endfunction

    function automatic box_t random_box();
        box_t b;
        case ($urandom_range(3))
            0: b = 93'({$urandom, $urandom, $urandom});
            1: b = make_box($urandom_range(4096) - 2048, $urandom_range(4096) - 2048,
                            $urandom_range(4096) - 2048, $urandom_range(1024),
                            $urandom_range(1024), $urandom_range(1024));
            2: b = {edge_value16(), edge_value16(), edge_value16(),
                    edge_half(), edge_half(), edge_half()};
            default: b = make_box($urandom, $urandom, $urandom, 0, 0, 0);
        endcase
        return b;
    endfunction

    task automatic directed_boxes();
        // no planes after reset: everything visible
        send_box(make_box(-32768, -32768, -32768, 0, 0, 0));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        drain_results();

        write_reg(REG_ACTIVE_PLANES, 1);
        write_reg(REG_PLANE_0, make_plane(16384, 0, 0, 0));
        send_box(make_box(-256, 0, 0, 256, 0, 0));       // touching the plane
        send_box(make_box(-257, 0, 0, 256, 0, 0));       // just past it
        send_box(make_box(-256, 0, 0, 255, 0, 0));
        send_box(make_box(-32768, 0, 0, 32767, 0, 0));
        send_box(make_box(-32768, 32767, -32768, 0, 32767, 32767));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        drain_results();

        // most negative offset against the largest center
        write_reg(REG_PLANE_0, make_plane(16384, 0, 0, -32768));
        send_box(make_box(32767, 0, 0, 1, 0, 0));
        send_box(make_box(32767, 0, 0, 0, 0, 0));
        send_box(make_box(32767, -32768, 32767, 0, 32767, 0));
        drain_results();

        // unnormalized extreme normals, plane count above the limit, dropped index
        write_reg(REG_ACTIVE_PLANES, 7);
        write_reg(REG_PLANE_0 + 3'd0, make_plane(-32768, -32768, -32768, 32767));
        write_reg(REG_PLANE_0 + 3'd1, make_plane(32767, 32767, 32767, -32768));
        write_reg(REG_PLANE_0 + 3'd2, make_plane(32767, -32768, 0, 0));
        write_reg(REG_PLANE_0 + 3'd3, make_plane(0, 32767, -32768, 256));
        write_reg(REG_PLANE_0 + 3'd4, make_plane(-32768, 0, 32767, -256));
        write_reg(REG_PLANE_0 + 3'd5, make_plane(0, 0, 16384, -32768));
        write_reg(REG_UNMAPPED, 64'h0000_0000_0000_ffff);
        send_box(make_box(-32768, -32768, -32768, 0, 0, 0));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(0, 0, 32767, 32767, 32767, 32767));
        for (int i = 0; i < 4; i++)
            send_box(random_box());
        drain_results();
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        reg_writes      = 0;
        box_ch.valid    = 1'b0;
        box_ch.center_x = '0;
        box_ch.center_y = '0;
        box_ch.center_z = '0;
        box_ch.half_x   = '0;
        box_ch.half_y   = '0;
        box_ch.half_z   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        res_ch.ready    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_boxes();

        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct  = 0;
            stall_pct = 0;
            write_reg(REG_ACTIVE_PLANES, 64'(phase_planes[p]));
            for (int i = 0; i < PLANE_SLOTS; i++)
                write_reg(REG_PLANE_0 + 3'(i), random_plane());
            if (p % 3 == 1)
                write_reg(REG_UNMAPPED, {$urandom, $urandom});
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int i = 0; i < PHASE_BOXES; i++)
            begin
                // sender holds off mid-phase until the pipe is empty
                if (i == PHASE_BOXES / 2)
                    drain_results();
                send_box(random_box());
            end
            drain_results();
        end

        $display("checked %0d boxes (%0d visible, %0d culled) over %0d plane setups",
                 sb.results_seen, sb.visible_seen, sb.culled_seen, PHASES + 4);
        $display("%0d register writes, %0d failures", reg_writes, sb.errors + sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("timeout waiting for the block");
        $display("testbench NOT OK");
        $finish;
    end

endmodule
